>>> rtl/assert_macros.svh
// Assertion macros for the feedback bus receiver RTL.
// Users need signals clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define RSFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define RSFB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/rsfb_pkg.sv
// Package for the feedback bus receiver: codes, constants and shared types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package rsfb_pkg;

  localparam int FifoDepth = 16;
  localparam int CmdqDepth = 2;
  localparam int OutqDepth = 4;

  localparam logic [15:0] GapTicksReset = 16'd5000;
  localparam logic [15:0] MinGap        = 16'd2;
  localparam logic [7:0]  AddrLimit     = 8'd129;
  localparam int          ShiftMsb      = 7;

  localparam logic [2:0] CMD_PULSE   = 3'd0;
  localparam logic [2:0] CMD_CLK_OVF = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_SAMPLE  = 3'd3;
  localparam logic [2:0] CMD_POP     = 3'd4;
  localparam logic [2:0] CMD_RD_OVF  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;
  localparam logic [1:0] ST_ADDR  = 2'd2;

  localparam logic [1:0] WAIT_STOP   = 2'd0;
  localparam logic [1:0] WAIT_SAMPLE = 2'd1;
  localparam logic [1:0] WAIT_BIT    = 2'd2;
  localparam logic [1:0] WAIT_HALF   = 2'd3;

  typedef enum logic [2:0] {
    OP_PULSE,
    OP_CLK_OVF,
    OP_START,
    OP_SAMPLE,
    OP_POP,
    OP_RD_OVF,
    OP_NONE
  } op_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_START,
    PH_BYTE,
    PH_STOP,
    PH_OVF
  } rx_phase_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] pulse_time;
    logic        line_level;
    logic        sample_late;
  } op_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] addr;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic       present;
    logic [1:0] status;
    logic [7:0] addr;
    logic [7:0] data;
    logic       ovf_seen;
    logic [1:0] next_wait;
    logic       start_armed;
  } result_t;

endpackage

>>> rtl/rsfb_front.sv
// Front end: accepts bus events, classifies the command and queues the operation.
// Depends on rsfb_pkg.
`timescale 1ns / 1ps
module rsfb_front #(
  parameter int Depth = rsfb_pkg::CmdqDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [2:0]      cmd_i,
  input  logic [15:0]     pulse_time_i,
  input  logic            line_level_i,
  input  logic            sample_late_i,
  output logic            op_valid_o,
  output rsfb_pkg::op_t   op_o,
  input  logic            op_pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rsfb_pkg::op_t     queue_q [Depth];
  rsfb_pkg::op_t     op_new;
  rsfb_pkg::op_kind_e kind;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              wr_en, rd_en;

  always_comb begin
    unique case (cmd_i)
      rsfb_pkg::CMD_PULSE:   kind = rsfb_pkg::OP_PULSE;
      rsfb_pkg::CMD_CLK_OVF: kind = rsfb_pkg::OP_CLK_OVF;
      rsfb_pkg::CMD_START:   kind = rsfb_pkg::OP_START;
      rsfb_pkg::CMD_SAMPLE:  kind = rsfb_pkg::OP_SAMPLE;
      rsfb_pkg::CMD_POP:     kind = rsfb_pkg::OP_POP;
      rsfb_pkg::CMD_RD_OVF:  kind = rsfb_pkg::OP_RD_OVF;
      default:               kind = rsfb_pkg::OP_NONE;
    endcase
  end

  assign op_new.kind        = kind;
  assign op_new.pulse_time  = pulse_time_i;
  assign op_new.line_level  = line_level_i;
  assign op_new.sample_late = sample_late_i;

  assign full_o     = (count_q == CntW'(Depth));
  assign op_valid_o = (count_q != '0);
  assign op_o       = queue_q[rd_ptr_q];
  assign wr_en      = push_i && !full_o;
  assign rd_en      = op_pop_i && op_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

>>> rtl/rsfb_exec.sv
// Back end: address counting, bit sampling, byte framing and the entry FIFO.
// Depends on rsfb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rsfb_exec #(
  parameter int FIFO_DEPTH = rsfb_pkg::FifoDepth,
  parameter int OutqDepth  = rsfb_pkg::OutqDepth,
  parameter int LevelW     = $clog2(OutqDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                op_valid_i,
  input  rsfb_pkg::op_t       op_i,
  output logic                op_pop_o,
  input  logic [LevelW-1:0]   outq_level_i,
  output logic                res_valid_o,
  output rsfb_pkg::result_t   res_o
);

  localparam int PtrW = $clog2(FIFO_DEPTH);

  rsfb_pkg::entry_t    mem [FIFO_DEPTH];
  rsfb_pkg::entry_t    rdata_q;
  rsfb_pkg::entry_t    push_entry;
  rsfb_pkg::rx_phase_e phase_q, phase_d;
  rsfb_pkg::op_kind_e  kind;

  logic [15:0]     gap_ticks_q;
  logic [7:0]      bus_addr_q, bus_addr_d;
  logic [15:0]     last_pulse_q, last_pulse_d;
  logic            addr_err_reported_q, addr_err_reported_d;
  logic            start_armed_q, start_armed_d;
  logic [1:0]      sample_idx_q, sample_idx_d;
  logic [1:0]      early_q, early_d;
  logic [7:0]      shift_q, shift_d;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PtrW-1:0] head_next, tail_next;
  logic            overflow_flag_q, overflow_flag_d;

  logic            fire;
  logic [15:0]     passed;
  logic            smp_active, smp_resolved, smp_bit;
  logic [1:0]      smp_idx_next, smp_early_next;
  logic            push_req, fifo_full, wr_en, rd_en;
  logic            present, ovf_seen;
  logic [1:0]      next_wait;

  logic            s2_valid_q;
  logic            s2_present_q, s2_ovf_q, s2_armed_q;
  logic [1:0]      s2_wait_q;

  assign fire     = op_valid_i && ((32'(outq_level_i) + 32'(s2_valid_q)) < OutqDepth);
  assign op_pop_o = fire;
  assign kind     = fire ? op_i.kind : rsfb_pkg::OP_NONE;
  assign passed   = op_i.pulse_time - last_pulse_q;

  assign head_next = (head_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign fifo_full = (head_next == tail_q);

  assign smp_active = (phase_q == rsfb_pkg::PH_START) || (phase_q == rsfb_pkg::PH_BYTE) ||
                      (phase_q == rsfb_pkg::PH_STOP);

  // Majority vote over up to three samples of one bit.
  always_comb begin
    smp_resolved   = 1'b1;
    smp_bit        = 1'b0;
    smp_idx_next   = 2'd0;
    smp_early_next = early_q;
    case (sample_idx_q)
      2'd0: begin
        if (!op_i.sample_late) begin
          smp_resolved   = 1'b0;
          smp_idx_next   = 2'd1;
          smp_early_next = {1'b0, op_i.line_level};
        end else begin
          smp_bit = op_i.line_level;
        end
      end
      2'd1: begin
        if (!op_i.sample_late) begin
          smp_resolved   = 1'b0;
          smp_idx_next   = 2'd2;
          smp_early_next = {early_q[0], op_i.line_level};
        end else begin
          smp_bit = early_q[0];
        end
      end
      default: begin
        if (op_i.sample_late) begin
          smp_bit = early_q[0];
        end else if (op_i.line_level) begin
          smp_bit = (early_q != 2'd0);
        end else begin
          smp_bit = (early_q == 2'd3);
        end
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    unique case (kind)
      rsfb_pkg::OP_PULSE: phase_d = rsfb_pkg::PH_ADDR;
      rsfb_pkg::OP_CLK_OVF: begin
        if (phase_q == rsfb_pkg::PH_ADDR) begin
          phase_d = rsfb_pkg::PH_OVF;
        end else if (phase_q == rsfb_pkg::PH_OVF) begin
          phase_d = rsfb_pkg::PH_IDLE;
        end
      end
      rsfb_pkg::OP_START: begin
        if (start_armed_q) begin
          phase_d = rsfb_pkg::PH_START;
        end
      end
      rsfb_pkg::OP_SAMPLE: begin
        if (smp_active && smp_resolved) begin
          case (phase_q)
            rsfb_pkg::PH_START: phase_d = smp_bit ? rsfb_pkg::PH_BYTE : rsfb_pkg::PH_ADDR;
            rsfb_pkg::PH_BYTE: begin
              if (shift_q[rsfb_pkg::ShiftMsb]) begin
                phase_d = rsfb_pkg::PH_STOP;
              end
            end
            default: phase_d = rsfb_pkg::PH_ADDR;
          endcase
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  always_comb begin
    bus_addr_d          = bus_addr_q;
    last_pulse_d        = last_pulse_q;
    addr_err_reported_d = addr_err_reported_q;
    start_armed_d       = start_armed_q;
    sample_idx_d        = sample_idx_q;
    early_d             = early_q;
    shift_d             = shift_q;
    tail_d              = tail_q;
    overflow_flag_d     = overflow_flag_q;
    push_req            = 1'b0;
    push_entry          = '0;
    rd_en               = 1'b0;
    present             = 1'b0;
    ovf_seen            = 1'b0;
    next_wait           = rsfb_pkg::WAIT_STOP;
    unique case (kind)
      rsfb_pkg::OP_PULSE: begin
        start_armed_d = 1'b1;
        last_pulse_d  = op_i.pulse_time;
        if (phase_q == rsfb_pkg::PH_IDLE) begin
          bus_addr_d = '0;
        end else begin
          sample_idx_d = 2'd0;
          if (passed > gap_ticks_q) begin
            bus_addr_d = '0;
          end else if (passed >= rsfb_pkg::MinGap) begin
            if (bus_addr_q >= rsfb_pkg::AddrLimit) begin
              bus_addr_d = rsfb_pkg::AddrLimit;
              if (!addr_err_reported_q) begin
                addr_err_reported_d = 1'b1;
                push_req            = 1'b1;
                push_entry.status   = rsfb_pkg::ST_ADDR;
                push_entry.addr     = rsfb_pkg::AddrLimit;
              end
            end else begin
              bus_addr_d = bus_addr_q + 8'd1;
            end
          end
        end
      end
      rsfb_pkg::OP_START: begin
        if (start_armed_q) begin
          start_armed_d = 1'b0;
          sample_idx_d  = 2'd0;
          next_wait     = rsfb_pkg::WAIT_HALF;
        end
      end
      rsfb_pkg::OP_SAMPLE: begin
        if (smp_active) begin
          sample_idx_d = smp_idx_next;
          early_d      = smp_early_next;
          if (!smp_resolved) begin
            next_wait = rsfb_pkg::WAIT_SAMPLE;
          end else begin
            case (phase_q)
              rsfb_pkg::PH_START: begin
                if (smp_bit) begin
                  shift_d   = 8'd1;
                  next_wait = rsfb_pkg::WAIT_BIT;
                end else begin
                  start_armed_d = 1'b1;
                end
              end
              rsfb_pkg::PH_BYTE: begin
                shift_d   = {shift_q[6:0], ~smp_bit};
                next_wait = rsfb_pkg::WAIT_BIT;
              end
              default: begin
                push_req          = 1'b1;
                push_entry.status = smp_bit ? rsfb_pkg::ST_FRAME : rsfb_pkg::ST_OK;
                push_entry.addr   = bus_addr_q;
                push_entry.data   = smp_bit ? 8'd0 : shift_q;
              end
            endcase
          end
        end
      end
      rsfb_pkg::OP_POP: begin
        if (head_q != tail_q) begin
          present = 1'b1;
          rd_en   = 1'b1;
          tail_d  = tail_next;
        end
      end
      rsfb_pkg::OP_RD_OVF: begin
        ovf_seen        = overflow_flag_q;
        overflow_flag_d = 1'b0;
      end
      default: ;
    endcase
    if (push_req && fifo_full) begin
      overflow_flag_d = 1'b1;
    end
  end

  assign wr_en  = push_req && !fifo_full;
  assign head_d = wr_en ? head_next : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q         <= rsfb_pkg::GapTicksReset;
      phase_q             <= rsfb_pkg::PH_IDLE;
      bus_addr_q          <= '0;
      last_pulse_q        <= '0;
      addr_err_reported_q <= 1'b0;
      start_armed_q       <= 1'b0;
      sample_idx_q        <= '0;
      early_q             <= '0;
      shift_q             <= '0;
      head_q              <= '0;
      tail_q              <= '0;
      overflow_flag_q     <= 1'b0;
      s2_valid_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gap_ticks_q <= cfg_wdata_i;
      end
      phase_q             <= phase_d;
      bus_addr_q          <= bus_addr_d;
      last_pulse_q        <= last_pulse_d;
      addr_err_reported_q <= addr_err_reported_d;
      start_armed_q       <= start_armed_d;
      sample_idx_q        <= sample_idx_d;
      early_q             <= early_d;
      shift_q             <= shift_d;
      head_q              <= head_d;
      tail_q              <= tail_d;
      overflow_flag_q     <= overflow_flag_d;
      s2_valid_q          <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[head_q] <= push_entry;
    end
    if (rd_en) begin
      rdata_q <= mem[tail_q];
    end
  end

  always_ff @(posedge clk_i) begin
    s2_present_q <= present;
    s2_ovf_q     <= ovf_seen;
    s2_wait_q    <= next_wait;
    s2_armed_q   <= start_armed_d;
  end

  assign res_valid_o       = s2_valid_q;
  assign res_o.present     = s2_present_q;
  assign res_o.status      = s2_present_q ? rdata_q.status : 2'd0;
  assign res_o.addr        = s2_present_q ? rdata_q.addr : 8'd0;
  assign res_o.data        = s2_present_q ? rdata_q.data : 8'd0;
  assign res_o.ovf_seen    = s2_ovf_q;
  assign res_o.next_wait   = s2_wait_q;
  assign res_o.start_armed = s2_armed_q;

  `RSFB_ASSERT(a_addr_range, bus_addr_q <= rsfb_pkg::AddrLimit, "bus address beyond limit")
  `RSFB_ASSERT(a_sample_idx, sample_idx_q != 2'd3, "sample index out of range")
  `RSFB_ASSERT_NEXT(a_err_sticky, addr_err_reported_q, addr_err_reported_q, "error flag cleared")
  `RSFB_ASSERT_NEXT(a_ovf_set, push_req && fifo_full, overflow_flag_q, "dropped entry not flagged")

endmodule

>>> rtl/rsfb_outq.sv
// Result queue between the back end and the consumer side.
// Depends on rsfb_pkg.
`timescale 1ns / 1ps
module rsfb_outq #(
  parameter int Depth  = rsfb_pkg::OutqDepth,
  parameter int LevelW = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rsfb_pkg::result_t   data_i,
  output logic [LevelW-1:0]   level_o,
  output logic                empty_o,
  input  logic                pop_i,
  output rsfb_pkg::result_t   data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  rsfb_pkg::result_t queue_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LevelW-1:0] count_q, count_d;
  logic              rd_en;

  assign empty_o = (count_q == '0);
  assign level_o = count_q;
  assign data_o  = queue_q[rd_ptr_q];
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + LevelW'(push_i) - LevelW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      queue_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/rs_feedback_bus_receiver_unit.sv
// Channel   Handshake            Payload
// input     push_i / full_o      cmd_i, pulse_time_i, line_level_i, sample_late_i
// result    empty_o / pop_i      entry_*_o, overflow_seen_o, next_wait_o, start_armed_out_o
// config    cfg_we_i             cfg_wdata_i (gap_ticks)
//
// One event per cycle sustained while the result queue has room.
// Each result passes the back-end s2 registers; the entry FIFO read is registered.
// Reset clears control state; entry FIFO contents are undefined until written.
// A 2-deep command queue and a 4-deep result queue let either side stall alone.
// Top level of the feedback bus receiver; depends on rsfb_pkg, rsfb_front,
// rsfb_exec and rsfb_outq.
`timescale 1ns / 1ps
module rs_feedback_bus_receiver_unit #(
  parameter int FIFO_DEPTH = rsfb_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] pulse_time_i,
  input  logic        line_level_i,
  input  logic        sample_late_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        entry_present_o,
  output logic [1:0]  entry_status_o,
  output logic [7:0]  entry_addr_o,
  output logic [7:0]  entry_data_o,
  output logic        overflow_seen_o,
  output logic [1:0]  next_wait_o,
  output logic        start_armed_out_o
);

  localparam int OutqDepth = rsfb_pkg::OutqDepth;
  localparam int LevelW    = $clog2(OutqDepth + 1);

  rsfb_pkg::op_t     op;
  rsfb_pkg::result_t res, head;
  logic              op_valid, op_pop, res_valid;
  logic [LevelW-1:0] outq_level;

  rsfb_front #(
    .Depth(rsfb_pkg::CmdqDepth)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i,
    .full_o,
    .cmd_i,
    .pulse_time_i,
    .line_level_i,
    .sample_late_i,
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  rsfb_exec #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .OutqDepth  (OutqDepth),
    .LevelW     (LevelW)
  ) u_exec (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .op_valid_i   (op_valid),
    .op_i         (op),
    .op_pop_o     (op_pop),
    .outq_level_i (outq_level),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  rsfb_outq #(
    .Depth  (OutqDepth),
    .LevelW (LevelW)
  ) u_outq (
    .clk_i,
    .rst_ni,
    .push_i  (res_valid),
    .data_i  (res),
    .level_o (outq_level),
    .empty_o,
    .pop_i,
    .data_o  (head)
  );

  assign entry_present_o   = head.present;
  assign entry_status_o    = head.status;
  assign entry_addr_o      = head.addr;
  assign entry_data_o      = head.data;
  assign overflow_seen_o   = head.ovf_seen;
  assign next_wait_o       = head.next_wait;
  assign start_armed_out_o = head.start_armed;

endmodule
